// ----- rtl/core/fed_pkg.sv -----
// fed_pkg: shared types and constants of the feedback echo delay core
// depends on: nothing

package fed_pkg;

    // input request payload
    typedef struct packed {
        logic signed [15:0] sample_in;
        logic               silent;
        logic               flush;
    } in_item_t;

    // result payload
    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               echo_active;
    } out_item_t;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WET      = 2'd2;

    // register reset values
    localparam logic [15:0] DELAY_RESET = 16'd44100;
    localparam logic [6:0]  FB_RESET    = 7'd50;
    localparam logic [6:0]  WET_RESET   = 7'd50;

    // full scale of the percent gains
    localparam logic [6:0] PCT_FULL = 7'd100;

    // truncating divide by 100 as a reciprocal multiply, exact for |x| below 2^23
    localparam logic [23:0] DIV100_MULT  = 24'd10737419;
    localparam int unsigned DIV100_SHIFT = 30;

    // gains as seen by the datapath
    typedef struct packed {
        logic [6:0] fb_pct;
        logic [6:0] wet_pct;
        logic [6:0] dry_pct;
    } gains_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic read;
        logic mac;
        logic scale;
        logic write;
    } cmd_t;

    // datapath and config to controller status
    typedef struct packed {
        logic cfg_busy;
        logic out_free;
    } status_t;

endpackage

// ----- rtl/core/fed_cfg.sv -----
// fed_cfg: configuration registers and the reduction of the delay modulo the store
// depth by a reciprocal multiply; depends on fed_pkg

module fed_cfg #(
    parameter int unsigned STORE_DEPTH = 65536
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  wr_en,
    input  logic [fed_pkg::CFG_IDX_W-1:0]         wr_index,
    input  logic [15:0]                           wr_data,
    output fed_pkg::gains_t                       gains,
    output logic [$clog2(STORE_DEPTH)-1:0]        delay_mod,
    output logic                                  busy
);
    import fed_pkg::*;

    localparam int unsigned AW  = $clog2(STORE_DEPTH);
    // shift and rounded-up reciprocal give an exact quotient for every 16-bit delay
    localparam int unsigned RSH = 16 + AW;
    localparam logic [17:0] RECIP =
        18'(((64'd1 << RSH) + 64'(STORE_DEPTH) - 64'd1) / 64'(STORE_DEPTH));
    localparam logic [31:0] DEPTH_W = 32'(STORE_DEPTH);

    // reduction steps
    localparam logic [1:0] STEP_DONE = 2'd0;
    localparam logic [1:0] STEP_REM  = 2'd1;
    localparam logic [1:0] STEP_QUOT = 2'd2;

    logic [6:0]    fb_reg;
    logic [6:0]    wet_reg;
    logic [15:0]   delay_reg;
    logic [15:0]   quot_reg;
    logic [1:0]    step_reg;
    logic [AW-1:0] rem_reg;
    logic [33:0]   quot_prod;
    logic [31:0]   rem_full;
    logic [6:0]    wet_clamped;

    // quotient by reciprocal multiply, then remainder by multiply and subtract
    always_comb begin
        quot_prod = 34'(delay_reg) * 34'(RECIP);
        rem_full  = 32'(delay_reg) - 32'(quot_reg) * DEPTH_W;
    end

    // register writes and the two-step reduction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fb_reg    <= FB_RESET;
            wet_reg   <= WET_RESET;
            delay_reg <= DELAY_RESET;
            quot_reg  <= '0;
            step_reg  <= STEP_QUOT;
            rem_reg   <= '0;
        end else if (wr_en) begin
            case (wr_index)
                CFG_DELAY: begin
                    delay_reg <= wr_data;
                    step_reg  <= STEP_QUOT;
                end
                CFG_FEEDBACK: fb_reg  <= wr_data[6:0];
                CFG_WET:      wet_reg <= wr_data[6:0];
                default: ;
            endcase
        end else if (step_reg == STEP_QUOT) begin
            quot_reg <= 16'(quot_prod >> RSH);
            step_reg <= STEP_REM;
        end else if (step_reg == STEP_REM) begin
            rem_reg  <= rem_full[AW-1:0];
            step_reg <= STEP_DONE;
        end
    end

    // wet share saturates at full scale
    assign wet_clamped   = (wet_reg > PCT_FULL) ? PCT_FULL : wet_reg;
    assign gains.fb_pct  = fb_reg;
    assign gains.wet_pct = wet_clamped;
    assign gains.dry_pct = PCT_FULL - wet_clamped;
    assign delay_mod     = rem_reg;
    assign busy          = (step_reg != STEP_DONE);

endmodule

// ----- rtl/core/fed_ctrl.sv -----
// fed_ctrl: controller state machine that steps one request through the datapath
// depends on fed_pkg

module fed_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fed_pkg::status_t  status,
    output fed_pkg::cmd_t     cmd
);
    import fed_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_SCALE,
        ST_WRITE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_valid && !status.cfg_busy) state_next = ST_READ;
            ST_READ:  state_next = ST_MAC;
            ST_MAC:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_WRITE;
            ST_WRITE: if (status.out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // command decode
    assign s_ready    = (state_reg == ST_IDLE) && !status.cfg_busy;
    assign cmd.accept = s_ready && s_valid;
    assign cmd.read   = (state_reg == ST_READ);
    assign cmd.mac    = (state_reg == ST_MAC);
    assign cmd.scale  = (state_reg == ST_SCALE);
    assign cmd.write  = (state_reg == ST_WRITE) && status.out_free;

endmodule

// ----- rtl/core/fed_dp.sv -----
// fed_dp: echo store, write pointer with fill tracking, mix arithmetic and result register
// depends on fed_pkg

module fed_dp #(
    parameter int unsigned STORE_DEPTH = 65536
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  fed_pkg::cmd_t                     cmd,
    input  fed_pkg::in_item_t                 in_item,
    input  fed_pkg::gains_t                   gains,
    input  logic [$clog2(STORE_DEPTH)-1:0]    delay_mod,
    output logic                              out_free,
    output logic                              m_valid,
    input  logic                              m_ready,
    output fed_pkg::out_item_t                m_data
);
    import fed_pkg::*;

    localparam int unsigned AW = $clog2(STORE_DEPTH);
    localparam logic [AW:0]   DEPTH = (AW+1)'(STORE_DEPTH);
    localparam logic [AW-1:0] LAST  = AW'(STORE_DEPTH - 1);

    // divide magnitude by 100, restore sign, saturate to 16 bits
    function automatic logic signed [15:0] scale_sat(input logic [47:0] prod,
                                                     input logic        neg);
        logic [17:0]        q;
        logic signed [18:0] sv;
        q  = prod[DIV100_SHIFT +: 18];
        sv = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        if (sv > 19'sd32767) begin
            return 16'sh7FFF;
        end else if (sv < -19'sd32768) begin
            return 16'sh8000;
        end
        return sv[15:0];
    endfunction

    logic signed [15:0] mem [STORE_DEPTH];

    logic [AW-1:0]      wp_reg;
    logic               wrapped_reg;
    logic signed [15:0] dry_reg;
    logic signed [15:0] rdata_reg;
    logic               hit_reg;
    logic signed [24:0] fb_sum_reg;
    logic signed [24:0] out_sum_reg;
    logic               echo_nz_reg;
    logic [47:0]        fb_prod_reg;
    logic [47:0]        out_prod_reg;
    logic               fb_neg_reg;
    logic               out_neg_reg;
    logic               m_valid_reg;
    out_item_t          m_data_reg;

    logic [AW:0]        diff;
    logic [AW:0]        diff_wrap;
    logic [AW-1:0]      rd_addr;
    logic               rd_hit;
    logic signed [15:0] echo;
    logic signed [24:0] fb_sum_next;
    logic signed [24:0] out_sum_next;
    logic [24:0]        fb_mag;
    logic [24:0]        out_mag;
    logic signed [15:0] fb_sat;
    logic signed [15:0] out_sat;

    // read address trails the write pointer by the reduced delay
    always_comb begin
        diff      = {1'b0, wp_reg} - {1'b0, delay_mod};
        diff_wrap = diff + DEPTH;
        rd_addr   = diff[AW] ? diff_wrap[AW-1:0] : diff[AW-1:0];
        // entries not written since the last clear read as zero
        rd_hit    = wrapped_reg || (rd_addr < wp_reg);
    end

    // echo store port: registered read, write of the feedback value
    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            rdata_reg <= mem[rd_addr];
        end
        if (cmd.write) begin
            mem[wp_reg] <= fb_sat;
        end
    end

    // write pointer and fill tracking, flush resets both
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
        end else if (cmd.accept && in_item.flush) begin
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
        end else if (cmd.write) begin
            if (wp_reg == LAST) begin
                wp_reg      <= '0;
                wrapped_reg <= 1'b1;
            end else begin
                wp_reg <= wp_reg + 1'b1;
            end
        end
    end

    // weighted sums of echo and dry sample
    always_comb begin
        echo         = hit_reg ? rdata_reg : 16'sd0;
        fb_sum_next  = 25'(echo) * 25'($signed({1'b0, gains.fb_pct}))
                     + 25'(dry_reg) * 25'($signed({1'b0, PCT_FULL}));
        out_sum_next = 25'(echo) * 25'($signed({1'b0, gains.wet_pct}))
                     + 25'(dry_reg) * 25'($signed({1'b0, gains.dry_pct}));
        fb_mag       = fb_sum_reg[24] ? -fb_sum_reg : fb_sum_reg;
        out_mag      = out_sum_reg[24] ? -out_sum_reg : out_sum_reg;
        fb_sat       = scale_sat(fb_prod_reg, fb_neg_reg);
        out_sat      = scale_sat(out_prod_reg, out_neg_reg);
    end

    // arithmetic pipeline registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            dry_reg <= in_item.silent ? 16'sd0 : in_item.sample_in;
        end
        if (cmd.read) begin
            hit_reg <= rd_hit;
        end
        if (cmd.mac) begin
            fb_sum_reg  <= fb_sum_next;
            out_sum_reg <= out_sum_next;
            echo_nz_reg <= (echo != 16'sd0);
        end
        if (cmd.scale) begin
            fb_prod_reg  <= 48'(fb_mag[23:0]) * 48'(DIV100_MULT);
            out_prod_reg <= 48'(out_mag[23:0]) * 48'(DIV100_MULT);
            fb_neg_reg   <= fb_sum_reg[24];
            out_neg_reg  <= out_sum_reg[24];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.write) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            m_data_reg.sample_out  <= out_sat;
            m_data_reg.echo_active <= echo_nz_reg;
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

endmodule

// ----- rtl/core/feedback_echo_delay_core.sv -----
// feedback_echo_delay_core: top level of the mono feedback echo
// depends on fed_pkg, fed_cfg, fed_ctrl, fed_dp

// Mono 16-bit feedback echo. Each sample request reads the echo written delay_samples
// requests earlier (delay reduced modulo STORE_DEPTH), stores back the saturated
// feedback mix and returns the saturated wet/dry mix with a flag for a nonzero echo.
// Store read, multiply-add, reciprocal scaling by 1/100 and write-back run in turn in
// states READ, MAC, SCALE and WRITE; the result register loads in WRITE, and the next
// request is taken only after the return to IDLE, once the last one is through.
// Write-back waits while the previous result still sits unaccepted in the result
// register. After reset and after each write of delay_samples, s_ready stays low while
// the delay is reduced by a reciprocal multiply and a multiply-subtract.
// Flush costs nothing extra: the store is treated as empty by tracking how far it
// has been written since the last clear, so there is no clearing pass after reset.

module feedback_echo_delay_core #(
    parameter int unsigned STORE_DEPTH = 65536
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fed_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [15:0]                         cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  fed_pkg::in_item_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output fed_pkg::out_item_t                  m_data
);
    import fed_pkg::*;

    localparam int unsigned AW = $clog2(STORE_DEPTH);

    gains_t        gains;
    logic [AW-1:0] delay_mod;
    logic          cfg_busy;
    logic          out_free;
    status_t       status;
    cmd_t          cmd;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    fed_cfg #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (cfg_valid && cfg_ready),
        .wr_index  (cfg_index),
        .wr_data   (cfg_data),
        .gains     (gains),
        .delay_mod (delay_mod),
        .busy      (cfg_busy)
    );

    assign status.cfg_busy = cfg_busy;
    assign status.out_free = out_free;

    fed_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    fed_dp #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_item   (s_data),
        .gains     (gains),
        .delay_mod (delay_mod),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // no request is taken while the delay reduction runs
    a_busy_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_busy |-> !s_ready)
        else $error("request taken during delay reduction");

    // one request at a time
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second request taken while one is in flight");

    // a result appears only from a write-back
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.write))
        else $error("result without write-back");

    // write-back never overruns a waiting result
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write |-> (!m_valid || m_ready))
        else $error("result register overrun");

endmodule

// ----- sim/fed_checker.sv -----
// fed_checker: scoreboard for the feedback echo delay core, with its own echo line model
// watches the register, request and result channels and counts mismatches
// depends on: fed_pkg

module fed_checker #(
    parameter int unsigned STORE_DEPTH = 65536
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [fed_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  fed_pkg::in_item_t             s_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  fed_pkg::out_item_t            m_data,
    output int                            fail_count,
    output int                            pending,
    output int                            result_count,
    output int                            echo_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import fed_pkg::*;

    // model state: echo line, write position and register copies
    logic signed [15:0] echo_line [STORE_DEPTH];
    int                 wr_ptr;
    logic [15:0]        delay_reg;
    logic [6:0]         fb_reg;
    logic [6:0]         wet_reg;
    out_item_t          mix_queue [$];
    int                 fails;
    int                 results;
    int                 echoes;

    initial begin
        fails        = 0;
        results      = 0;
        echoes       = 0;
    end

    function automatic int clamp16(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic void clear_line();
        for (int i = 0; i < STORE_DEPTH; i++) echo_line[i] = '0;
        wr_ptr = 0;
    endfunction

    // one sample through the echo: read behind the write position, then write back
    function automatic out_item_t echo_step(in_item_t req);
        int dry;
        int echo;
        int wet_eff;
        int fb_mix;
        int out_mix;
        int lag;
        int rd_pos;
        out_item_t res;
        dry = req.silent ? 0 : int'($signed(req.sample_in));
        if (req.flush) clear_line();
        lag     = int'(delay_reg) % STORE_DEPTH;
        rd_pos  = (wr_ptr + STORE_DEPTH - lag) % STORE_DEPTH;
        echo    = int'(echo_line[rd_pos]);
        wet_eff = (wet_reg > PCT_FULL) ? int'(PCT_FULL) : int'(wet_reg);
        fb_mix  = clamp16((echo * int'(fb_reg) + dry * int'(PCT_FULL)) / int'(PCT_FULL));
        out_mix = clamp16((echo * wet_eff + dry * (int'(PCT_FULL) - wet_eff))
                          / int'(PCT_FULL));
        echo_line[wr_ptr] = 16'(fb_mix);
        wr_ptr = (wr_ptr + 1) % STORE_DEPTH;
        res.sample_out  = 16'(out_mix);
        res.echo_active = (echo != 0);
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        out_item_t want;
        if (!aresetn) begin
            clear_line();
            delay_reg = DELAY_RESET;
            fb_reg    = FB_RESET;
            wet_reg   = WET_RESET;
            mix_queue.delete();
        end else begin
            // results first: a result never belongs to a request taken at the same edge
            if (m_valid && m_ready) begin
                if (mix_queue.size() == 0) begin
                    fails++;
                    $display("%0t: result with none pending, actual %0d/%0b",
                             $realtime, $signed(m_data.sample_out), m_data.echo_active);
                end else begin
                    want = mix_queue.pop_front();
                    results++;
                    if (want.echo_active) echoes++;
                    if (m_data.sample_out !== want.sample_out) begin
                        fails++;
                        $display("%0t: sample_out expected %0d actual %0d", $realtime,
                                 $signed(want.sample_out), $signed(m_data.sample_out));
                    end
                    if (m_data.echo_active !== want.echo_active) begin
                        fails++;
                        $display("%0t: echo_active expected %0b actual %0b", $realtime,
                                 want.echo_active, m_data.echo_active);
                    end
                end
            end
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DELAY:    delay_reg = cfg_data;
                    CFG_FEEDBACK: fb_reg    = cfg_data[6:0];
                    CFG_WET:      wet_reg   = cfg_data[6:0];
                    default: ;
                endcase
            end
            // sample requests
            if (s_valid && s_ready) mix_queue.push_back(echo_step(s_data));
        end
        fail_count   <= fails;
        pending      <= mix_queue.size();
        result_count <= results;
        echo_count   <= echoes;
    end

endmodule

// ----- sim/tb_feedback_echo_delay_core.sv -----
// tb_feedback_echo_delay_core: stimulus and verdict for the feedback echo delay core
// drives registers and sample requests under varying idle patterns; checking is in fed_checker
// depends on: fed_pkg, feedback_echo_delay_core, fed_checker

module tb_feedback_echo_delay_core;
    timeunit 1ns;
    timeprecision 1ps;
    import fed_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;

    int fail_count;
    int pending;
    int result_count;
    int echo_count;

    int snd_idle_pct = 20;
    int rcv_idle_pct = 55;
    int samples_sent = 0;
    int flushes      = 0;
    int settings     = 0;

    feedback_echo_delay_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    fed_checker i_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count),
        .echo_count   (echo_count)
    );

    // 50 MHz clock
    always #10 aclk = ~aclk;

    // result side back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // hard stop
    initial begin
        #20_000_000;
        $display("feedback_echo_delay_core verification failed");
        $finish;
    end

    // register write, valid left high for back-to-back writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // drain, then load all registers; junk fills the unused upper bits of the gains
    task automatic configure(input logic [15:0] dly, input logic [6:0] fb,
                             input logic [6:0] wet, input bit junk, input bit spare);
        logic [8:0] hi_fb;
        logic [8:0] hi_wet;
        hi_fb  = junk ? 9'($urandom) : '0;
        hi_wet = junk ? 9'($urandom) : '0;
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (spare) write_reg(CFG_SPARE, 16'($urandom));
        write_reg(CFG_DELAY, dly);
        write_reg(CFG_FEEDBACK, {hi_fb, fb});
        write_reg(CFG_WET, {hi_wet, wet});
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // one sample request with an optional random gap ahead of it
    task automatic send_sample(input in_item_t req);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        samples_sent++;
        if (req.flush) flushes++;
    endtask

    task automatic send_plain(input logic signed [15:0] v, input logic sil, input logic fl);
        send_sample(in_item_t'{sample_in: v, silent: sil, flush: fl});
    endtask

    // mostly full-range audio, some rails, some small values for truncation
    function automatic in_item_t rand_sample();
        in_item_t req;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)      req.sample_in = 16'($urandom);
        else if (pick < 68) req.sample_in = 16'sh7fff;
        else if (pick < 76) req.sample_in = 16'sh8000;
        else                req.sample_in = 16'($urandom_range(0, 600) - 300);
        req.silent = ($urandom_range(0, 99) < 10);
        req.flush  = ($urandom_range(0, 99) < 2);
        return req;
    endfunction

    initial begin : stimulus
        logic [15:0] dly;
        logic [6:0]  fb;
        logic [6:0]  wet;
        int          wait_cnt;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: rails, zero, silence and a flush
        send_plain(16'sh7fff, 1'b0, 1'b0);
        send_plain(16'sh8000, 1'b0, 1'b0);
        send_plain(16'sh0000, 1'b0, 1'b0);
        send_plain(-16'sd1, 1'b0, 1'b0);
        send_plain(16'sd12345, 1'b1, 1'b0);
        send_plain(-16'sd5, 1'b0, 1'b1);
        s_valid <= 1'b0;

        // shortest nonzero delay, gains beyond range: stored value saturates, output is pure echo
        configure(16'd1, 7'd127, 7'd127, 1'b0, 1'b0);
        repeat (3) send_plain(16'sh7fff, 1'b0, 1'b0);
        repeat (3) send_plain(16'sh8000, 1'b0, 1'b0);
        send_plain(16'sd1, 1'b0, 1'b0);
        send_plain(-16'sd1, 1'b0, 1'b0);
        send_plain(-16'sd99, 1'b0, 1'b0);
        send_plain(16'sd777, 1'b1, 1'b0);
        send_plain(16'sd777, 1'b1, 1'b0);
        send_plain(16'sd50, 1'b0, 1'b1);
        s_valid <= 1'b0;

        // zero delay reads the entry about to be written, all dry output
        configure(16'd0, 7'd99, 7'd0, 1'b0, 1'b1);
        send_plain(16'sd1000, 1'b0, 1'b0);
        send_plain(-16'sd3, 1'b0, 1'b0);
        send_plain(16'sh7fff, 1'b0, 1'b0);
        s_valid <= 1'b0;

        // no feedback, all wet
        configure(16'd2, 7'd0, 7'd100, 1'b0, 1'b0);
        send_plain(16'sd2000, 1'b0, 1'b0);
        send_plain(-16'sd2000, 1'b0, 1'b0);
        send_plain(16'sd1, 1'b0, 1'b0);
        s_valid <= 1'b0;

        // random phases over several settings and idle patterns
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin dly = 16'($urandom_range(1, 16)); fb = 7'd99; wet = 7'd50; end
                1: begin
                    dly = 16'($urandom_range(1, 64));
                    fb  = 7'($urandom_range(0, 127));
                    wet = 7'($urandom_range(0, 127));
                end
                2: begin dly = 16'hffff; fb = 7'd0; wet = 7'd100; end
                3: begin
                    dly = 16'($urandom);
                    fb  = 7'($urandom_range(0, 127));
                    wet = 7'($urandom_range(0, 127));
                end
                4: begin dly = 16'($urandom_range(1, 8)); fb = 7'd127; wet = 7'd127; end
                5: begin
                    dly = 16'($urandom_range(1, 4));
                    fb  = 7'($urandom_range(0, 20));
                    wet = 7'($urandom_range(0, 30));
                end
                default: begin
                    dly = 16'($urandom_range(1, 32));
                    fb  = 7'($urandom_range(50, 99));
                    wet = 7'($urandom_range(0, 100));
                end
            endcase
            if (ph < 3) begin
                snd_idle_pct = 20;
                rcv_idle_pct = 55;
            end else if (ph < 5) begin
                snd_idle_pct = 55;
                rcv_idle_pct = 20;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            configure(dly, fb, wet, 1'b1, 1'b0);
            repeat (150) send_sample(rand_sample());
            s_valid <= 1'b0;
        end

        // drain and let the pipeline settle
        wait_cnt = 0;
        while (pending != 0 && wait_cnt < 20000) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (16) @(posedge aclk);

        $display("sent %0d samples over %0d register settings, %0d with flush",
                 samples_sent, settings, flushes);
        $display("checked %0d results, %0d of them with a live echo",
                 result_count, echo_count);
        if (pending != 0) $display("%0d results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("feedback_echo_delay_core verification clean");
        end else begin
            $display("feedback_echo_delay_core verification failed");
        end
        $finish;
    end

endmodule
